### hw/rtl/iplm_pkg.sv
// ============================================================================
// iplm_pkg
// Shared types, constants and mask helpers for the IP prefix list matcher.
// ============================================================================
package iplm_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TBL_AW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 128;

    localparam logic [7:0] V4_BITS = 8'd32;
    localparam logic [7:0] V6_BITS = 8'd128;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_PFX_LONG  = 2'd1,
        ERR_HOST_BITS = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              v6;
        logic [7:0]        prefix;
        logic [ADDR_W-1:0] net;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              wr_en;
        logic [TBL_AW-1:0] wr_addr;
        t_entry            wr_data;
        logic              rd_en;
        logic [TBL_AW-1:0] rd_addr;
    } t_ram_req;

    // Leading-ones mask in network order; IPv4 sits in the low 32 bits.
    function automatic logic [ADDR_W-1:0] f_mask(input logic v6, input logic [7:0] p);
        logic [ADDR_W-1:0] m6;
        logic [31:0]       m4;
        m6 = ~({ADDR_W{1'b1}} >> p);
        m4 = ~(32'hFFFF_FFFF >> p);
        return v6 ? m6 : {96'b0, m4};
    endfunction

    function automatic logic [ADDR_W-1:0] f_canon(input logic v6, input logic [63:0] hi,
                                                  input logic [63:0] lo);
        return v6 ? {hi, lo} : {96'b0, lo[31:0]};
    endfunction

endpackage

### hw/rtl/ip_prefix_list_match.sv
// ============================================================================
// ip_prefix_list_match
// IPv4/IPv6 prefix table: error-free loads write one slot, lookup
// transactions report whether any valid slot of the family covers an address.
// ============================================================================
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+---------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_mode i_slot i_family_v6 i_addr_hi
//          |             |             | i_addr_lo i_prefix_given i_prefix_len
//  out     | o_out_valid | i_out_ready | o_hit o_error
//
//  Load: capture, check/write, result, in that order from acceptance.
//  Lookup: the scan reads one slot per cycle through the table RAM's single read
//  port and stops at a hit.
//  Reset clears the per-slot valid flops at once; there is no clearing pass.
//  One transaction is in flight at a time; a finished result waits in the
//  output register, and a stalled output only holds the sequencer at its
//  final step until that register frees up.
//
module ip_prefix_list_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [3:0]  i_slot,
    input  logic        i_family_v6,
    input  logic [63:0] i_addr_hi,
    input  logic [63:0] i_addr_lo,
    input  logic        i_prefix_given,
    input  logic [7:0]  i_prefix_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic [1:0]  o_error
);

    import iplm_pkg::*;

    t_ram_req ram_req;
    t_entry   rd_data;

    iplm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    iplm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_slot         (i_slot),
        .i_family_v6    (i_family_v6),
        .i_addr_hi      (i_addr_hi),
        .i_addr_lo      (i_addr_lo),
        .i_prefix_given (i_prefix_given),
        .i_prefix_len   (i_prefix_len),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hit          (o_hit),
        .o_error        (o_error),
        .o_ram_req      (ram_req),
        .i_rd_data      (rd_data)
    );

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a transaction while another is in flight");

    a_err_no_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error != ERR_OK) |-> !o_hit)
        else $error("result carries both an error and a hit");

    a_no_rw_overlap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> !ram_req.rd_en)
        else $error("table write overlaps a scan read");

    a_no_write_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_req.wr_en |-> !o_in_ready)
        else $error("table write outside a load transaction");

endmodule

### hw/rtl/iplm_ram.sv
// ============================================================================
// iplm_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module iplm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/iplm_chk.sv
// ============================================================================
// iplm_chk
// Load validation: resolves the prefix length and flags too-long prefixes
// and host bits set outside the mask.
// ============================================================================
module iplm_chk (
    input  logic                          i_v6,
    input  logic [iplm_pkg::ADDR_W-1:0]   i_addr,
    input  logic                          i_given,
    input  logic [7:0]                    i_plen,
    output iplm_pkg::t_err                o_err,
    output logic [7:0]                    o_prefix
);

    import iplm_pkg::*;

    logic [7:0]        width;
    logic [7:0]        plen;
    logic [ADDR_W-1:0] mask;

    always_comb begin
        width = i_v6 ? V6_BITS : V4_BITS;
        plen  = i_given ? i_plen : width;
        mask  = f_mask(i_v6, plen);
        priority if (plen > width) begin
            o_err = ERR_PFX_LONG;
        end else if ((i_addr & ~mask) != '0) begin
            o_err = ERR_HOST_BITS;
        end else begin
            o_err = ERR_OK;
        end
    end

    assign o_prefix = plen;

endmodule

### hw/rtl/iplm_seq.sv
// ============================================================================
// iplm_seq
// Transaction sequencer: captures an item, writes the table on loads, scans
// the table one slot per cycle on lookups, and holds the result register.
// ============================================================================
module iplm_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [3:0]           i_slot,
    input  logic                 i_family_v6,
    input  logic [63:0]          i_addr_hi,
    input  logic [63:0]          i_addr_lo,
    input  logic                 i_prefix_given,
    input  logic [7:0]           i_prefix_len,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_hit,
    output logic [1:0]           o_error,
    output iplm_pkg::t_ram_req   o_ram_req,
    input  iplm_pkg::t_entry     i_rd_data
);

    import iplm_pkg::*;

    localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(TABLE_ENTRIES - 1);

    t_state            r_state, n_state;
    logic [3:0]        r_slot;
    logic              r_v6;
    logic [ADDR_W-1:0] r_addr;
    logic              r_given;
    logic [7:0]        r_plen;
    logic [TBL_AW-1:0] r_idx, n_idx;
    logic              r_rd_pend, n_rd_pend;
    logic [TBL_AW-1:0] r_rd_idx, n_rd_idx;
    logic              r_rd_done, n_rd_done;
    logic              r_res_hit, n_res_hit;
    t_err              r_res_err, n_res_err;
    logic              r_out_valid, n_out_valid;
    logic              r_out_hit, n_out_hit;
    t_err              r_out_err, n_out_err;
    logic              r_valid [TABLE_ENTRIES];

    t_err              chk_err;
    logic [7:0]        chk_prefix;
    logic              slot_ok;
    logic              match;
    logic              accept;
    t_ram_req          ram_req;

    iplm_chk u_chk (
        .i_v6     (r_v6),
        .i_addr   (r_addr),
        .i_given  (r_given),
        .i_plen   (r_plen),
        .o_err    (chk_err),
        .o_prefix (chk_prefix)
    );

    assign slot_ok = (9'(r_slot) < 9'(TABLE_ENTRIES));
    assign match   = r_valid[r_rd_idx] && (i_rd_data.v6 == r_v6) &&
                     ((r_addr & f_mask(r_v6, i_rd_data.prefix)) == i_rd_data.net);
    assign accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_rd_pend   = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_rd_done   = r_rd_done;
        n_res_hit   = r_res_hit;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_hit   = r_out_hit;
        n_out_err   = r_out_err;
        o_in_ready  = 1'b0;
        ram_req     = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_idx     = '0;
                    n_rd_done = 1'b0;
                    n_res_hit = 1'b0;
                    n_res_err = ERR_OK;
                    n_state   = i_mode ? S_SCAN : S_LOAD;
                end
            end
            S_LOAD: begin
                n_res_err = chk_err;
                if (chk_err == ERR_OK && slot_ok) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = TBL_AW'(r_slot);
                    ram_req.wr_data = '{v6: r_v6, prefix: chk_prefix, net: r_addr};
                end
                n_state = S_FIN;
            end
            S_SCAN: begin
                if (!r_rd_done) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = r_idx;
                    n_rd_pend       = 1'b1;
                    n_rd_idx        = r_idx;
                    if (r_idx == TBL_LAST) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_idx = TBL_AW'(r_idx + 1'b1);
                    end
                end
                if (r_rd_pend) begin
                    if (match) begin
                        n_res_hit = 1'b1;
                        n_state   = S_FIN;
                    end else if (r_rd_idx == TBL_LAST) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pend   <= 1'b0;
            r_rd_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_rd_done   <= n_rd_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (ram_req.wr_en) begin
            r_valid[ram_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot  <= i_slot;
            r_v6    <= i_family_v6;
            r_addr  <= f_canon(i_family_v6, i_addr_hi, i_addr_lo);
            r_given <= i_prefix_given;
            r_plen  <= i_prefix_len;
        end
        r_idx     <= n_idx;
        r_rd_idx  <= n_rd_idx;
        r_res_hit <= n_res_hit;
        r_res_err <= n_res_err;
        r_out_hit <= n_out_hit;
        r_out_err <= n_out_err;
    end

    assign o_ram_req   = ram_req;
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_error     = r_out_err;

endmodule
